@@ hw/rtl/ssd_pkg.sv @@
// Package for the seven-segment time display writer.
// Holds the command and bus-write word types, codes, segment table and small helpers.
// No dependencies.
package ssd_pkg;

	localparam logic [1:0] OP_DIGITS = 2'd0;
	localparam logic [1:0] OP_TIME   = 2'd1;
	localparam logic [1:0] OP_CTRL   = 2'd2;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_DIGITS = 2'd1;
	localparam logic [1:0] KIND_CTRL   = 2'd2;

	localparam logic [7:0]  CTRL_ADDR   = 8'h48;
	localparam logic [7:0]  POINT_BIT   = 8'h80;
	localparam logic [18:0] MAX_SECONDS = 19'd359999;
	localparam logic [11:0] SEC_PER_HR  = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN = 6'd60;
	localparam logic [19:0] HR_RECIP    = 20'd596524;
	localparam logic [14:0] MIN_RECIP   = 15'd17477;
	localparam logic [7:0]  TEN_RECIP   = 8'd205;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  digit_0;
		logic [3:0]  digit_1;
		logic [3:0]  digit_2;
		logic [3:0]  digit_3;
		logic        point_on;
		logic [18:0] seconds;
		logic        power_on;
		logic [2:0]  brightness;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] bus_address;
		logic [7:0] bus_data;
		logic       last_write;
	} wr_word_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [3:0][7:0] bytes;
	} wr_set_t;

	function automatic logic [7:0] seg7(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'h0: s = 8'h3f;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5b;
			4'h3: s = 8'h4f;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6d;
			4'h6: s = 8'h7d;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7f;
			4'h9: s = 8'h6f;
			4'ha: s = 8'h77;
			4'hb: s = 8'h7c;
			4'hc: s = 8'h39;
			4'hd: s = 8'h5e;
			4'he: s = 8'h79;
			default: s = 8'h71;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] digit_addr(input logic [1:0] idx);
		logic [7:0] a;
		case (idx)
			2'd0: a = 8'h68;
			2'd1: a = 8'h6a;
			2'd2: a = 8'h6c;
			default: a = 8'h6e;
		endcase
		return a;
	endfunction

	// tens digit of a value below 100
	function automatic logic [3:0] tens(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'(TEN_RECIP);
		return p[14:11];
	endfunction

	function automatic logic [3:0] ones(input logic [6:0] v);
		logic [6:0] t;
		t = 7'(tens(v)) * 7'd10;
		return 4'(v - t);
	endfunction

endpackage

@@ hw/rtl/ssd_serializer.sv @@
// Write serializer: takes one prepared set of bytes and emits its bus writes one per cycle while wr_stall is low.
// Depends on ssd_pkg.
module ssd_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              set_valid,
	input  ssd_pkg::wr_set_t  set,
	output logic              set_ready,
	output logic              wr_valid,
	input  logic              wr_stall,
	output ssd_pkg::wr_word_t wr
);
	import ssd_pkg::*;

	logic            busy_q;
	logic            ctrl_q;
	logic [1:0]      idx_q;
	logic [3:0][7:0] bytes_q;
	logic            last;
	logic            take;

	assign last      = ctrl_q || (idx_q == 2'd3);
	assign set_ready = !busy_q || (!wr_stall && last);
	assign take      = set_valid && set_ready;

	assign wr_valid       = busy_q;
	assign wr.bus_address = ctrl_q ? CTRL_ADDR : digit_addr(idx_q);
	assign wr.bus_data    = bytes_q[idx_q];
	assign wr.last_write  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ctrl_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			busy_q <= (set.kind != KIND_NONE);
			ctrl_q <= (set.kind == KIND_CTRL);
			idx_q  <= 2'd0;
		end else if (busy_q && !wr_stall) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bytes_q <= set.bytes;
		end
	end

endmodule

@@ hw/rtl/seven_segment_time_display_writer.sv @@
// Seven-segment time display writer, top level.
// Depends on ssd_pkg and ssd_serializer.
//
// Usage: each word on the cmd channel is one display command. Opcode 0 writes four
// hex digits, opcode 1 shows a count of seconds as MM:SS (below one hour) or HH:MM,
// opcode 2 writes the power/brightness control byte, opcode 3 gives nothing.
// Each word on the wr channel is one bus write: address byte, data byte and a
// last_write flag on the final write of a command.
// Both channels use valid/stall; a word moves when valid is high and stall is low.
// The first write of a command appears after it passes stages s1 to s6 and is taken into the serializer.
// One command per cycle enters the six-stage conversion pipeline while cmd_stall is low;
// the output serializer emits one write per cycle while wr_stall is low, and a digit
// command makes four writes and a control command one.
// When wr_stall is high the serializer holds its write, the pipeline fills and
// cmd_stall rises once every stage holds a word; nothing is lost or repeated.
// Reset clears all valid bits and the serializer; no clearing pass is needed.
module seven_segment_time_display_writer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  ssd_pkg::cmd_word_t cmd,
	output logic               wr_valid,
	input  logic               wr_stall,
	output ssd_pkg::wr_word_t  wr
);
	import ssd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic ser_ready;

	cmd_word_t word_s1, word_s2, word_s3, word_s4, word_s5;
	logic [18:0] t_s1, t_s2;
	logic [6:0]  hr_s2, hr_s3, hr_s4, hr_s5;
	logic [11:0] rem_s3, rem_s4;
	logic [5:0]  mn_s4, mn_s5;
	logic [5:0]  sc_s5;
	wr_set_t     set_s6;

	logic [38:0] hr_prod;
	logic [18:0] hr_sec;
	logic [26:0] mn_prod;
	logic [11:0] mn_sec;
	logic [3:0]  tdig [4];
	wr_set_t     set_d;

	assign rdy_s6 = !v_s6 || ser_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign cmd_stall = !rdy_s1;

	assign hr_prod = 39'(t_s1) * 39'(HR_RECIP);
	assign hr_sec  = 19'(hr_s2) * 19'(SEC_PER_HR);
	assign mn_prod = 27'(rem_s3) * 27'(MIN_RECIP);
	assign mn_sec  = 12'(mn_s4) * 12'(SEC_PER_MIN);

	always_comb begin
		if (hr_s5 == 7'd0) begin
			tdig[0] = tens(7'(mn_s5));
			tdig[1] = ones(7'(mn_s5));
			tdig[2] = tens(7'(sc_s5));
			tdig[3] = ones(7'(sc_s5));
		end else begin
			tdig[0] = tens(hr_s5);
			tdig[1] = ones(hr_s5);
			tdig[2] = tens(7'(mn_s5));
			tdig[3] = ones(7'(mn_s5));
		end
		set_d.kind  = KIND_NONE;
		set_d.bytes = '0;
		case (word_s5.opcode)
			OP_DIGITS: begin
				set_d.kind     = KIND_DIGITS;
				set_d.bytes[0] = seg7(word_s5.digit_0) | (word_s5.point_on ? POINT_BIT : 8'h00);
				set_d.bytes[1] = seg7(word_s5.digit_1) | (word_s5.point_on ? POINT_BIT : 8'h00);
				set_d.bytes[2] = seg7(word_s5.digit_2) | (word_s5.point_on ? POINT_BIT : 8'h00);
				set_d.bytes[3] = seg7(word_s5.digit_3) | (word_s5.point_on ? POINT_BIT : 8'h00);
			end
			OP_TIME: begin
				set_d.kind     = KIND_DIGITS;
				set_d.bytes[0] = seg7(tdig[0]) | POINT_BIT;
				set_d.bytes[1] = seg7(tdig[1]) | POINT_BIT;
				set_d.bytes[2] = seg7(tdig[2]) | POINT_BIT;
				set_d.bytes[3] = seg7(tdig[3]) | POINT_BIT;
			end
			OP_CTRL: begin
				set_d.kind     = KIND_CTRL;
				set_d.bytes[0] = {1'b0, word_s5.brightness, 3'b000, word_s5.power_on};
			end
			default: begin
				set_d.kind = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cmd_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && cmd_valid) begin
			word_s1 <= cmd;
			t_s1    <= (cmd.seconds > MAX_SECONDS) ? MAX_SECONDS : cmd.seconds;
		end
		if (rdy_s2 && v_s1) begin
			word_s2 <= word_s1;
			t_s2    <= t_s1;
			hr_s2   <= hr_prod[37:31];
		end
		if (rdy_s3 && v_s2) begin
			word_s3 <= word_s2;
			hr_s3   <= hr_s2;
			rem_s3  <= 12'(t_s2 - hr_sec);
		end
		if (rdy_s4 && v_s3) begin
			word_s4 <= word_s3;
			hr_s4   <= hr_s3;
			rem_s4  <= rem_s3;
			mn_s4   <= mn_prod[25:20];
		end
		if (rdy_s5 && v_s4) begin
			word_s5 <= word_s4;
			hr_s5   <= hr_s4;
			mn_s5   <= mn_s4;
			sc_s5   <= 6'(rem_s4 - mn_sec);
		end
		if (rdy_s6 && v_s5) begin
			set_s6 <= set_d;
		end
	end

	ssd_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_valid (v_s6),
		.set       (set_s6),
		.set_ready (ser_ready),
		.wr_valid  (wr_valid),
		.wr_stall  (wr_stall),
		.wr        (wr)
	);

`ifndef NO_ASSERTIONS
	a_ctrl_last : assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr.bus_address == CTRL_ADDR |-> wr.last_write)
		else $error("control write not marked last");

	a_digit_last : assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr.last_write && wr.bus_address != CTRL_ADDR |-> wr.bus_address == 8'h6e)
		else $error("digit sequence ended early");

	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6)
		else $error("input stalled with a free pipeline slot");
`endif

endmodule
